// ===== rtl/plc_pkg.sv =====
// plc_pkg: types and constants shared by the pressure level cooldown block
// no dependencies
`default_nettype none

package plc_pkg;

    localparam int unsigned PCT_W      = 7;
    localparam int unsigned PRESSURE_W = 20;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned GEN_W      = 16;
    localparam int unsigned SCALED_W   = PRESSURE_W + PCT_W;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_ELEVATED = 2'd1,
        LVL_HIGH     = 2'd2,
        LVL_CRITICAL = 2'd3
    } t_level;

    typedef enum logic {
        CMD_EVAL  = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ELEVATED_PCT = 2'd0,
        REG_HIGH_PCT     = 2'd1,
        REG_CRITICAL_PCT = 2'd2,
        REG_COOLDOWN     = 2'd3
    } t_reg_idx;

    localparam logic [PCT_W-1:0]  ELEVATED_PCT_RST = 7'd70;
    localparam logic [PCT_W-1:0]  HIGH_PCT_RST     = 7'd85;
    localparam logic [PCT_W-1:0]  CRITICAL_PCT_RST = 7'd95;
    localparam logic [TIME_W-1:0] COOLDOWN_RST     = 32'd5000;

    typedef struct packed {
        logic [PCT_W-1:0]  thr_elevated;
        logic [PCT_W-1:0]  thr_high;
        logic [PCT_W-1:0]  thr_critical;
        logic [TIME_W-1:0] cooldown;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/plc_if.sv =====
// plc_in_if / plc_out_if: valid-ready channels for samples and results
// depends on plc_pkg
`default_nettype none

interface plc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [plc_pkg::PRESSURE_W-1:0]    pressure_fixed;
    logic [plc_pkg::TIME_W-1:0]        sample_time;
    logic [plc_pkg::GEN_W-1:0]         threshold_generation;

    modport source (output valid, output cmd, output pressure_fixed,
                    output sample_time, output threshold_generation, input ready);
    modport sink   (input valid, input cmd, input pressure_fixed,
                    input sample_time, input threshold_generation, output ready);
endinterface

interface plc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] raw_class;
    logic [1:0] held_class;

    modport source (output valid, output raw_class, output held_class, input ready);
    modport sink   (input valid, input raw_class, input held_class, output ready);
endinterface

`default_nettype wire

// ===== rtl/pressure_level_cooldown.sv =====
// pressure_level_cooldown: top level, input register, classify, hold state, result register
// depends on plc_pkg, plc_if, plc_cfg, plc_classify, plc_hold
`default_nettype none

// Memory pressure level with a sticky cooldown. Each sample transaction on i_in is
// registered, classified against the three percentage thresholds and applied to the
// held level as it moves from the input register into the result register that drives
// o_out. One sample per clock is sustained back to back while o_out.ready is high:
// the held-state register updates once per transaction. While a result waits on o_out,
// one more sample can be taken into the input register; after that i_in.ready stays low
// until the result is accepted. The user must write registers over the APB port only
// while no sample is in flight; the block itself does not enforce this.
module pressure_level_cooldown (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [plc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [plc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [plc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    plc_in_if.sink                                 i_in,
    plc_out_if.source                              o_out
);

    plc_pkg::t_cfg                     w_cfg;
    plc_pkg::t_level                   w_raw;
    plc_pkg::t_level                   w_held_next;
    plc_pkg::t_level                   w_held;
    logic                              w_advance;

    logic                              r_s1_valid;
    plc_pkg::t_cmd                     r_s1_cmd;
    logic [plc_pkg::PRESSURE_W-1:0]    r_s1_pressure;
    logic [plc_pkg::TIME_W-1:0]        r_s1_time;
    logic [plc_pkg::GEN_W-1:0]         r_s1_gen;

    logic                              r_out_valid;
    plc_pkg::t_level                   r_out_raw;
    plc_pkg::t_level                   r_out_held;

    plc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    plc_classify u_classify (
        .i_pressure (r_s1_pressure),
        .i_cfg      (w_cfg),
        .o_raw      (w_raw)
    );

    plc_hold u_hold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_advance),
        .i_cmd       (r_s1_cmd),
        .i_raw       (w_raw),
        .i_now       (r_s1_time),
        .i_gen       (r_s1_gen),
        .i_cooldown  (w_cfg.cooldown),
        .o_held_next (w_held_next),
        .o_held      (w_held)
    );

    // stage 1 moves into the result register when that slot is free or being drained
    assign w_advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_cmd      <= plc_pkg::t_cmd'(i_in.cmd);
            r_s1_pressure <= i_in.pressure_fixed;
            r_s1_time     <= i_in.sample_time;
            r_s1_gen      <= i_in.threshold_generation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_raw  <= w_raw;
            r_out_held <= w_held_next;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.raw_class  = r_out_raw;
    assign o_out.held_class = r_out_held;

    // a clear transaction always reports normal
    a_clear_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_s1_cmd == plc_pkg::CMD_CLEAR
        |=> o_out.held_class == plc_pkg::LVL_NORMAL)
        else $error("held level not normal after clear");

    // an evaluated sample never holds below its raw level
    a_held_ge_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_s1_cmd == plc_pkg::CMD_EVAL
        |=> o_out.held_class >= o_out.raw_class)
        else $error("held level below raw level");

    // a stalled result stays valid and unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready
        |=> o_out.valid && $stable(o_out.raw_class) && $stable(o_out.held_class))
        else $error("result changed while stalled");

    // the held state only changes when a sample moves through
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(w_held))
        else $error("held level changed without a transaction");

endmodule

`default_nettype wire

// ===== rtl/plc_cfg.sv =====
// plc_cfg: apb register file for thresholds and cooldown interval
// depends on plc_pkg
`default_nettype none

module plc_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [plc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [plc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [plc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output plc_pkg::t_cfg                          o_cfg
);

    plc_pkg::t_cfg     r_cfg;
    plc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = plc_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_elevated <= plc_pkg::ELEVATED_PCT_RST;
            r_cfg.thr_high     <= plc_pkg::HIGH_PCT_RST;
            r_cfg.thr_critical <= plc_pkg::CRITICAL_PCT_RST;
            r_cfg.cooldown     <= plc_pkg::COOLDOWN_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                plc_pkg::REG_ELEVATED_PCT: r_cfg.thr_elevated <= pwdata[plc_pkg::PCT_W-1:0];
                plc_pkg::REG_HIGH_PCT:     r_cfg.thr_high     <= pwdata[plc_pkg::PCT_W-1:0];
                plc_pkg::REG_CRITICAL_PCT: r_cfg.thr_critical <= pwdata[plc_pkg::PCT_W-1:0];
                plc_pkg::REG_COOLDOWN:     r_cfg.cooldown     <= pwdata[plc_pkg::TIME_W-1:0];
                default:                   r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            plc_pkg::REG_ELEVATED_PCT: prdata = {25'd0, r_cfg.thr_elevated};
            plc_pkg::REG_HIGH_PCT:     prdata = {25'd0, r_cfg.thr_high};
            plc_pkg::REG_CRITICAL_PCT: prdata = {25'd0, r_cfg.thr_critical};
            plc_pkg::REG_COOLDOWN:     prdata = r_cfg.cooldown;
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/plc_classify.sv =====
// plc_classify: sorts a fixed-point pressure into a raw level
// depends on plc_pkg
`default_nettype none

module plc_classify (
    input  wire logic [plc_pkg::PRESSURE_W-1:0] i_pressure,
    input  wire plc_pkg::t_cfg                  i_cfg,
    output plc_pkg::t_level                     o_raw
);

    logic [plc_pkg::SCALED_W-1:0] w_scaled;
    logic                         w_crit;
    logic                         w_high;
    logic                         w_elev;

    function automatic logic meets(input logic [plc_pkg::SCALED_W-1:0] scaled,
                                   input logic [plc_pkg::PCT_W-1:0]    pct);
        logic [plc_pkg::SCALED_W-1:0] thr;
        thr   = {{(plc_pkg::PRESSURE_W-plc_pkg::FRAC_W){1'b0}}, pct, {plc_pkg::FRAC_W{1'b0}}};
        meets = scaled >= thr;
    endfunction

    // pressure * 100 as 64p + 32p + 4p
    assign w_scaled = ({7'd0, i_pressure} << 6) + ({7'd0, i_pressure} << 5)
                    + ({7'd0, i_pressure} << 2);

    assign w_crit = meets(w_scaled, i_cfg.thr_critical);
    assign w_high = meets(w_scaled, i_cfg.thr_high);
    assign w_elev = meets(w_scaled, i_cfg.thr_elevated);

    always_comb begin
        priority if (w_crit) o_raw = plc_pkg::LVL_CRITICAL;
        else if (w_high)     o_raw = plc_pkg::LVL_HIGH;
        else if (w_elev)     o_raw = plc_pkg::LVL_ELEVATED;
        else                 o_raw = plc_pkg::LVL_NORMAL;
    end

endmodule

`default_nettype wire

// ===== rtl/plc_hold.sv =====
// plc_hold: held level, generation and cooldown start with the step-down rule
// depends on plc_pkg
`default_nettype none

module plc_hold (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_update,
    input  wire plc_pkg::t_cmd               i_cmd,
    input  wire plc_pkg::t_level             i_raw,
    input  wire logic [plc_pkg::TIME_W-1:0]  i_now,
    input  wire logic [plc_pkg::GEN_W-1:0]   i_gen,
    input  wire logic [plc_pkg::TIME_W-1:0]  i_cooldown,
    output plc_pkg::t_level                  o_held_next,
    output plc_pkg::t_level                  o_held
);

    plc_pkg::t_level              r_level, n_level;
    logic [plc_pkg::GEN_W-1:0]    r_gen, n_gen;
    logic [plc_pkg::TIME_W-1:0]   r_start, n_start;
    logic [plc_pkg::TIME_W-1:0]   w_elapsed;
    logic                         w_up;
    logic                         w_down;

    assign w_elapsed = i_now - r_start;
    assign w_up      = (i_raw >= r_level) || (i_gen != r_gen);
    assign w_down    = w_elapsed >= i_cooldown;

    always_comb begin
        n_level = r_level;
        n_gen   = r_gen;
        n_start = r_start;
        if (i_cmd == plc_pkg::CMD_CLEAR) begin
            n_level = plc_pkg::LVL_NORMAL;
            n_gen   = '0;
            n_start = '0;
        end else begin
            priority if (w_up) begin
                n_level = i_raw;
            end else if (w_down) begin
                n_level = plc_pkg::t_level'(r_level - 2'd1);
            end else begin
                n_level = r_level;
            end
            // normal keeps the stored generation and time
            if ((w_up || w_down) && n_level != plc_pkg::LVL_NORMAL) begin
                n_gen   = i_gen;
                n_start = i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= plc_pkg::LVL_NORMAL;
            r_gen   <= '0;
            r_start <= '0;
        end else if (i_update) begin
            r_level <= n_level;
            r_gen   <= n_gen;
            r_start <= n_start;
        end
    end

    assign o_held_next = n_level;
    assign o_held      = r_level;

endmodule

`default_nettype wire
